FILE: rtl/mbsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MIDI byte stream parser.
// Used by mbsp_ctrl, mbsp_dp and midi_byte_stream_parser_unit; no dependencies.
package mbsp_pkg;

  localparam int SYSEX_MAX_DEF = 32;
  localparam int LEN_W         = 6;
  localparam int TDATA_W       = 48;
  localparam int TUSER_W       = 4;

  localparam logic [7:0] MIDI_RT_MIN   = 8'hF8;
  localparam logic [7:0] MIDI_SX_END   = 8'hF7;
  localparam logic [7:0] MIDI_SX_START = 8'hF0;
  localparam logic [7:0] MIDI_SYS_MIN  = 8'hF1;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROG     = 4'hC;
  localparam logic [3:0] NIB_CH_PRESS = 4'hD;
  localparam logic [3:0] NIB_BEND     = 4'hE;

  typedef enum logic [3:0] {
    KIND_REALTIME = 4'd0,
    KIND_ACTIVITY = 4'd1,
    KIND_NOTE_OFF = 4'd2,
    KIND_NOTE_ON  = 4'd3,
    KIND_CONTROL  = 4'd4,
    KIND_PROGRAM  = 4'd5,
    KIND_BEND     = 4'd6,
    KIND_SX_BYTE  = 4'd7,
    KIND_SX_END   = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  channel;
    logic [6:0]  key_or_number;
    logic [6:0]  amount;
    logic [13:0] bend_value;
    logic [7:0]  byte_value;
    logic [5:0]  sysex_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic parse;
    logic drain_adv;
    logic end_emit;
  } mbsp_cmd_t;

  typedef struct packed {
    logic hold_valid;
    logic out_free;
    logic sysex_end;
    logic len_zero;
    logic drain_last;
  } mbsp_stat_t;

endpackage

FILE: rtl/mbsp_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences parse, system-exclusive drain and end item.
// Depends on mbsp_pkg.
module mbsp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mbsp_pkg::mbsp_stat_t   stat,
  output mbsp_pkg::mbsp_cmd_t    cmd
);
  import mbsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DRAIN  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.parse     = 1'b0;
    cmd.drain_adv = 1'b0;
    cmd.end_emit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (stat.hold_valid && stat.out_free) begin
          cmd.parse = 1'b1;
          if (stat.sysex_end) begin
            state_nxt = stat.len_zero ? ST_FINISH : ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.drain_adv = 1'b1;
          if (stat.drain_last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.end_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/mbsp_dp.sv
`timescale 1ns / 1ps
// Datapath: input hold register, parse state, system-exclusive memory, output register.
// Depends on mbsp_pkg; driven by mbsp_ctrl commands.
module mbsp_dp #(
  parameter int SYSEX_MAX = mbsp_pkg::SYSEX_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output mbsp_pkg::result_t     out_res,
  input  mbsp_pkg::mbsp_cmd_t   cmd,
  output mbsp_pkg::mbsp_stat_t  stat
);
  import mbsp_pkg::*;

  localparam int IDX_W = (SYSEX_MAX > 1) ? $clog2(SYSEX_MAX) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(SYSEX_MAX);

  logic             hold_valid_r, hold_valid_nxt;
  logic [7:0]       hold_byte_r;
  logic [7:0]       rs_r, rs_nxt;
  logic             cnt_r, cnt_nxt;
  logic [1:0]       need_r, need_nxt;
  logic [6:0]       first_r, first_nxt;
  logic             sx_r, sx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [6:0]       mem_q_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;
  result_t          par_res;
  logic             par_emit;
  logic             mem_we;
  logic             out_free;
  logic             drain_last;
  logic [7:0]       b;
  logic [6:0]       d0, d1;
  logic [6:0]       mem [SYSEX_MAX];

  assign b          = hold_byte_r;
  assign in_tready  = !hold_valid_r;
  assign out_free   = !out_valid_r || out_tready;
  assign drain_last = (LEN_W'(rd_idx_r) + LEN_W'(1)) == len_r;

  assign stat.hold_valid = hold_valid_r;
  assign stat.out_free   = out_free;
  assign stat.sysex_end  = (b == MIDI_SX_END) && sx_r;
  assign stat.len_zero   = (len_r == '0);
  assign stat.drain_last = drain_last;

  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

  always_comb begin
    rs_nxt    = rs_r;
    cnt_nxt   = cnt_r;
    need_nxt  = need_r;
    first_nxt = first_r;
    sx_nxt    = sx_r;
    len_nxt   = len_r;
    mem_we    = 1'b0;
    par_emit  = 1'b0;
    par_res   = '0;
    d0        = '0;
    d1        = '0;
    if (cmd.parse) begin
      if (b >= MIDI_RT_MIN) begin
        par_emit           = 1'b1;
        par_res.kind       = KIND_REALTIME;
        par_res.byte_value = b;
      end else if (b == MIDI_SX_END) begin
        par_emit = 1'b0;
      end else if (b == MIDI_SX_START) begin
        sx_nxt  = 1'b1;
        len_nxt = '0;
        rs_nxt  = '0;
      end else if (b >= MIDI_SYS_MIN) begin
        rs_nxt = '0;
        sx_nxt = 1'b0;
      end else if (b[7]) begin
        sx_nxt   = 1'b0;
        rs_nxt   = b;
        cnt_nxt  = 1'b0;
        need_nxt = (b[7:4] == NIB_PROG || b[7:4] == NIB_CH_PRESS) ? 2'd1 : 2'd2;
        par_emit        = 1'b1;
        par_res.kind    = KIND_ACTIVITY;
        par_res.channel = b[3:0];
      end else if (sx_r) begin
        if (len_r < LEN_MAX) begin
          mem_we  = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end else if (rs_r != '0) begin
        if (!cnt_r && need_r == 2'd2) begin
          first_nxt = b[6:0];
          cnt_nxt   = 1'b1;
        end else begin
          cnt_nxt = 1'b0;
          if (need_r == 2'd1) begin
            d0 = b[6:0];
            d1 = '0;
          end else begin
            d0 = first_r;
            d1 = b[6:0];
          end
          par_res.channel = rs_r[3:0];
          case (rs_r[7:4])
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_CTRL: begin
              par_emit = 1'b1;
              if (rs_r[7:4] == NIB_CTRL) begin
                par_res.kind = KIND_CONTROL;
              end else if (rs_r[7:4] == NIB_NOTE_ON && d1 != '0) begin
                par_res.kind = KIND_NOTE_ON;
              end else begin
                par_res.kind = KIND_NOTE_OFF;
              end
              par_res.key_or_number = d0;
              par_res.amount        = d1;
            end
            NIB_PROG: begin
              par_emit              = 1'b1;
              par_res.kind          = KIND_PROGRAM;
              par_res.key_or_number = d0;
            end
            NIB_BEND: begin
              par_emit           = 1'b1;
              par_res.kind       = KIND_BEND;
              par_res.bend_value = {d1, d0};
            end
            default: begin
              par_emit = 1'b0;
            end
          endcase
        end
      end
      par_res.last = par_emit;
    end
    if (cmd.end_emit) begin
      sx_nxt = 1'b0;
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.parse && par_emit) begin
      res_nxt = par_res;
    end else if (cmd.drain_adv) begin
      res_nxt             = '0;
      res_nxt.kind        = KIND_SX_BYTE;
      res_nxt.byte_value  = {1'b0, mem_q_r};
      res_nxt.sysex_count = LEN_W'(rd_idx_r);
    end else if (cmd.end_emit) begin
      res_nxt             = '0;
      res_nxt.kind        = KIND_SX_END;
      res_nxt.sysex_count = len_r;
      res_nxt.last        = 1'b1;
    end
  end

  always_comb begin
    if ((cmd.parse && par_emit) || cmd.drain_adv || cmd.end_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    hold_valid_nxt = hold_valid_r;
    if (in_tvalid && in_tready) begin
      hold_valid_nxt = 1'b1;
    end else if (cmd.parse) begin
      hold_valid_nxt = 1'b0;
    end
    rd_idx_nxt = rd_idx_r;
    if (cmd.drain_adv) begin
      rd_idx_nxt = drain_last ? '0 : rd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len_r[IDX_W-1:0]] <= b[6:0];
    end
    mem_q_r <= mem[rd_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_byte_r <= in_tdata;
    end
    first_r <= first_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rs_r         <= '0;
      cnt_r        <= 1'b0;
      need_r       <= '0;
      sx_r         <= 1'b0;
      len_r        <= '0;
      rd_idx_r     <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      rs_r         <= rs_nxt;
      cnt_r        <= cnt_nxt;
      need_r       <= need_nxt;
      sx_r         <= sx_nxt;
      len_r        <= len_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  a_end_in_sysex: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_emit |-> sx_r)
    else $error("sysex end item issued outside sysex");

  a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_adv |-> (LEN_W'(rd_idx_r) < len_r))
    else $error("drain index beyond stored length");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("sysex length beyond capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.parse || cmd.drain_adv || cmd.end_emit) |-> out_free)
    else $error("output register overwritten while occupied");

endmodule

FILE: rtl/midi_byte_stream_parser_unit.sv
`timescale 1ns / 1ps
// MIDI byte stream parser with running status, top level.
// Instantiates mbsp_ctrl and mbsp_dp; depends on mbsp_pkg.
//
// Usage: each transaction on the in_ channel carries one received MIDI byte.
// The out_ channel returns zero or more events per byte; out_tuser gives the
// event kind and out_tlast marks the final event caused by that byte.
// An event is loaded into the output register, and out_tvalid rises, at the
// edge where its byte is parsed from the input register. Bytes are held in a
// one-entry input register, so a new byte is taken while an event waits in
// the output register. The input register frees only at the edge where its
// byte is parsed, so a new byte is not taken before the held one is parsed.
// A system-exclusive end byte with N stored bytes (at most SYSEX_MAX) is parsed,
// then the single read port of the sysex memory drains one stored byte per cycle
// while the output register is free, and the end transaction follows.
// Reset clears the running status, sysex state and both holding registers;
// no clearing pass is needed. When out_tready is low the pending event holds,
// parsing stops, and in_tready drops once the input register fills.
module midi_byte_stream_parser_unit #(
  parameter int SYSEX_MAX = mbsp_pkg::SYSEX_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] in_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [3:0] channel, [10:4] key_or_number, [17:11] amount, [31:18] bend_value,
  // [39:32] byte_value, [45:40] sysex_count, [47:46] zero
  output logic [mbsp_pkg::TDATA_W-1:0] out_tdata,
  output logic [mbsp_pkg::TUSER_W-1:0] out_tuser,  // [3:0] event_kind
  output logic                         out_tlast
);
  import mbsp_pkg::*;

  mbsp_cmd_t  cmd;
  mbsp_stat_t stat;
  result_t    res;

  mbsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  mbsp_dp #(
    .SYSEX_MAX (SYSEX_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign out_tdata = {2'b00, res.sysex_count, res.byte_value, res.bend_value,
                      res.amount, res.key_or_number, res.channel};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for midi_byte_stream_parser_unit: a parser model follows each
// accepted MIDI byte and the events on the out_ stream are checked against it in order.
// Depends on mbsp_pkg and the RTL of the parser; needs no files or arguments.
module tb_top;
  import mbsp_pkg::*;

  localparam int SX_DEPTH      = SYSEX_MAX_DEF;
  localparam int RANDOM_BYTES  = 100;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;

  class midi_event_scoreboard;
    result_t     pending_events[$];
    int unsigned errors;
    logic [7:0]  run_status;
    logic [1:0]  data_seen;
    logic [1:0]  data_need;
    logic [6:0]  first_byte;
    bit          sx_open;
    logic [5:0]  sx_len;
    logic [6:0]  sx_bytes[SX_DEPTH];

    function new();
      errors     = 0;
      run_status = '0;
      data_seen  = '0;
      data_need  = '0;
      first_byte = '0;
      sx_open    = 1'b0;
      sx_len     = '0;
      foreach (sx_bytes[i]) sx_bytes[i] = '0;
    endfunction

    function void add_event(kind_t kind, logic [3:0] chan, logic [6:0] key, logic [6:0] amt,
                            logic [13:0] bend, logic [7:0] bval, logic [5:0] cnt);
      result_t ev;
      ev.kind          = kind;
      ev.channel       = chan;
      ev.key_or_number = key;
      ev.amount        = amt;
      ev.bend_value    = bend;
      ev.byte_value    = bval;
      ev.sysex_count   = cnt;
      ev.last          = 1'b0;
      pending_events.push_back(ev);
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned depth_before;
      logic [3:0]  hi;
      logic [3:0]  chan;
      logic [6:0]  d0;
      logic [6:0]  d1;
      kind_t       kind;
      depth_before = pending_events.size();
      hi           = b[7:4];
      if (b >= MIDI_RT_MIN) begin
        add_event(KIND_REALTIME, '0, '0, '0, '0, b, '0);
      end else if (b == MIDI_SX_END) begin
        if (sx_open) begin
          for (int i = 0; i < sx_len; i++)
            add_event(KIND_SX_BYTE, '0, '0, '0, '0, {1'b0, sx_bytes[i]}, 6'(i));
          add_event(KIND_SX_END, '0, '0, '0, '0, '0, sx_len);
          sx_open = 1'b0;
        end
      end else if (b == MIDI_SX_START) begin
        sx_open    = 1'b1;
        sx_len     = '0;
        run_status = '0;
      end else if (b >= MIDI_SYS_MIN) begin
        run_status = '0;
        sx_open    = 1'b0;
      end else if (b[7]) begin
        sx_open    = 1'b0;
        run_status = b;
        data_seen  = '0;
        data_need  = (hi == NIB_PROG || hi == NIB_CH_PRESS) ? 2'd1 : 2'd2;
        add_event(KIND_ACTIVITY, b[3:0], '0, '0, '0, '0, '0);
      end else if (sx_open) begin
        if (sx_len < SX_DEPTH) begin
          sx_bytes[sx_len] = b[6:0];
          sx_len           = sx_len + 6'd1;
        end
      end else if (run_status != '0) begin
        if (data_seen == 2'd0 && data_need == 2'd2) begin
          first_byte = b[6:0];
          data_seen  = 2'd1;
        end else begin
          d0        = (data_need == 2'd1) ? b[6:0] : first_byte;
          d1        = (data_need == 2'd1) ? 7'd0 : b[6:0];
          data_seen = 2'd0;
          hi        = run_status[7:4];
          chan      = run_status[3:0];
          case (hi)
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_CTRL: begin
              if (hi == NIB_CTRL) kind = KIND_CONTROL;
              else if (hi == NIB_NOTE_ON && d1 != 7'd0) kind = KIND_NOTE_ON;
              else kind = KIND_NOTE_OFF;
              add_event(kind, chan, d0, d1, '0, '0, '0);
            end
            NIB_PROG: add_event(KIND_PROGRAM, chan, d0, '0, '0, '0, '0);
            NIB_BEND: add_event(KIND_BEND, chan, '0, '0, {d1, d0}, '0, '0);
            default: ;
          endcase
        end
      end
      if (pending_events.size() > depth_before)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
      if (errors < 50)
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
      errors++;
    endtask

    task check_event(result_t got);
      result_t want;
      if (pending_events.size() == 0) begin
        report_mismatch("event with nothing pending", got, 0);
        return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind) report_mismatch("event_kind", got.kind, want.kind);
      if (got.channel !== want.channel) report_mismatch("channel", got.channel, want.channel);
      if (got.key_or_number !== want.key_or_number)
        report_mismatch("key_or_number", got.key_or_number, want.key_or_number);
      if (got.amount !== want.amount) report_mismatch("amount", got.amount, want.amount);
      if (got.bend_value !== want.bend_value)
        report_mismatch("bend_value", got.bend_value, want.bend_value);
      if (got.byte_value !== want.byte_value)
        report_mismatch("byte_value", got.byte_value, want.byte_value);
      if (got.sysex_count !== want.sysex_count)
        report_mismatch("sysex_count", got.sysex_count, want.sysex_count);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic [TUSER_W-1:0]  out_tuser;
  logic                out_tlast;

  result_t              seen_event;
  midi_event_scoreboard midi_events;
  int unsigned          cycle_count = 0;
  int unsigned          bytes_sent  = 0;
  int unsigned          burst_left  = 0;
  int unsigned          rdy_left    = 0;
  logic [1:0]           rdy_mode    = 2'd0;

  logic [7:0] directed_bytes[$] = '{
    8'h3C, MIDI_SX_END, 8'hF8, 8'hFF,
    8'h90, 8'h3C, 8'h40, 8'h00, 8'h00,
    8'h8F, 8'h7F, 8'h7F,
    8'hB0, 8'h00, 8'h7F,
    8'hC5, 8'h7F,
    8'hD1, 8'h33,
    8'hA2, 8'h10, 8'h20,
    8'hE3, 8'h7F, 8'h00, 8'h00, 8'h7F,
    MIDI_SX_START, 8'h01, 8'hF8, 8'h7F, MIDI_SX_END,
    MIDI_SX_START, MIDI_SX_END,
    MIDI_SX_START, 8'h22, 8'hF3, 8'h33, MIDI_SX_END,
    MIDI_SX_START, 8'h44, 8'h95, 8'h10, 8'h20
  };

  midi_byte_stream_parser_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always_comb begin
    seen_event.kind          = kind_t'(out_tuser);
    seen_event.channel       = out_tdata[3:0];
    seen_event.key_or_number = out_tdata[10:4];
    seen_event.amount        = out_tdata[17:11];
    seen_event.bend_value    = out_tdata[31:18];
    seen_event.byte_value    = out_tdata[39:32];
    seen_event.sysex_count   = out_tdata[45:40];
    seen_event.last          = out_tlast;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) midi_events.check_event(seen_event);
      if (in_tvalid && in_tready) midi_events.take_byte(in_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= 2'($urandom_range(0, 3));
      rdy_left <= $urandom_range(8, 80);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rdy_left % 5) < 2;
    endcase
  end

  task automatic send_byte(input logic [7:0] value);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      @(negedge clk) in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk) in_tvalid <= 1'b0;
    while (midi_events.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [6:0] rand_data();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 7'h7F : 7'h00;
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic send_sysex_body(input int unsigned count);
    send_byte(MIDI_SX_START);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(MIDI_RT_MIN, 8'hFF)));
      send_byte({1'b0, rand_data()});
    end
  endtask

  task automatic send_voice();
    logic [7:0]  status;
    int unsigned need;
    status = {4'($urandom_range(NIB_NOTE_OFF, NIB_BEND)), 4'($urandom_range(0, 15))};
    need   = (status[7:4] == NIB_PROG || status[7:4] == NIB_CH_PRESS) ? 1 : 2;
    if ($urandom_range(0, 3) != 0) send_byte(status);
    repeat ($urandom_range(1, 3)) begin
      repeat (need) send_byte({1'b0, rand_data()});
    end
  endtask

  initial begin
    int unsigned random_start;
    bit          paused;
    midi_events = new();
    paused      = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_sysex_body(SX_DEPTH + 3);
    send_byte(MIDI_SX_END);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_voice();
        5: send_byte(8'($urandom_range(MIDI_RT_MIN, 8'hFF)));
        6, 7: begin
          send_sysex_body(($urandom_range(0, 7) == 0) ? $urandom_range(28, 38)
                                                     : $urandom_range(0, 6));
          case ($urandom_range(0, 5))
            0: send_byte(8'($urandom_range(8'h80, 8'hEF)));
            1: send_byte(8'($urandom_range(MIDI_SYS_MIN, 8'hF6)));
            default: send_byte(MIDI_SX_END);
          endcase
        end
        8: send_byte(8'($urandom));
        default: send_byte(8'($urandom_range(MIDI_SYS_MIN, MIDI_SX_END)));
      endcase
      if (!paused && bytes_sent - random_start > RANDOM_BYTES / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    @(negedge clk) in_tvalid <= 1'b0;
    while (midi_events.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (midi_events.pending_events.size() != 0)
      midi_events.report_mismatch("events never seen", 0, midi_events.pending_events.size());
    if (midi_events.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mbsp_pkg.sv
rtl/mbsp_ctrl.sv
rtl/mbsp_dp.sv
rtl/midi_byte_stream_parser_unit.sv
tb/tb_top.sv
